>>> rtl/core/afc37_pkg.sv
// ----------------------------------------------------------------------------
// afc37_pkg: shared types, constants and tables of the mod-37 affine cipher
// Symbol alphabet, register indexes, key set type and reduction tables.
// ----------------------------------------------------------------------------
package afc37_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned SYM_W  = 6;
	localparam int unsigned IDX_W  = 2;

	localparam logic [SYM_W-1:0] MODULUS     = 6'd37;
	localparam logic [SYM_W-1:0] SPACE_SYM   = 6'd10;
	localparam logic [SYM_W-1:0] LETTER_BASE = 6'd11;

	localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] ASCII_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] ASCII_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] ASCII_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] ASCII_LZ    = 8'h7A;

	// register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_KEY_MULT = 2'd0;
	localparam logic [IDX_W-1:0] REG_KEY_ADD  = 2'd1;

	localparam logic [0:0] MODE_ENCRYPT = 1'b0;
	localparam logic [0:0] MODE_DECRYPT = 1'b1;

	// keys as the datapath sees them: already reduced mod 37
	typedef struct packed {
		logic [SYM_W-1:0] mult;
		logic [SYM_W-1:0] inv;
		logic [SYM_W-1:0] add;
	} key_set_t;

	// multiplicative inverses mod 37; entry 0 has none
	localparam logic [SYM_W-1:0] INV_TABLE [37] = '{
		6'd0,  6'd1,  6'd19, 6'd25, 6'd28, 6'd15, 6'd31, 6'd16, 6'd14, 6'd33,
		6'd26, 6'd27, 6'd34, 6'd20, 6'd8,  6'd5,  6'd7,  6'd24, 6'd35, 6'd2,
		6'd13, 6'd30, 6'd32, 6'd29, 6'd17, 6'd3,  6'd10, 6'd11, 6'd4,  6'd23,
		6'd21, 6'd6,  6'd22, 6'd9,  6'd12, 6'd18, 6'd36
	};

	// (h * 32) mod 37 for the upper bits h of an 11-bit sum (h at most 41)
	localparam logic [SYM_W-1:0] FOLD32_TABLE [42] = '{
		6'd0,  6'd32, 6'd27, 6'd22, 6'd17, 6'd12, 6'd7,  6'd2,  6'd34, 6'd29,
		6'd24, 6'd19, 6'd14, 6'd9,  6'd4,  6'd36, 6'd31, 6'd26, 6'd21, 6'd16,
		6'd11, 6'd6,  6'd1,  6'd33, 6'd28, 6'd23, 6'd18, 6'd13, 6'd8,  6'd3,
		6'd35, 6'd30, 6'd25, 6'd20, 6'd15, 6'd10, 6'd5,  6'd0,  6'd32, 6'd27,
		6'd22, 6'd17
	};

	// reduce a 6-bit value mod 37 with one compare and subtract
	function automatic logic [SYM_W-1:0] reduce37(input logic [SYM_W-1:0] v);
		reduce37 = (v >= MODULUS) ? (v - MODULUS) : v;
	endfunction

endpackage

>>> rtl/core/afc37_xform.sv
// ----------------------------------------------------------------------------
// afc37_xform: character transform of the mod-37 affine cipher
// Maps a byte to a symbol, applies the affine map or its inverse, maps back.
// ----------------------------------------------------------------------------
module afc37_xform (
	input  logic                          mode,
	input  logic [afc37_pkg::CHAR_W-1:0] char_in,
	input  afc37_pkg::key_set_t           keys,
	output logic [afc37_pkg::CHAR_W-1:0] char_out,
	output logic                          key_error
);

	logic [afc37_pkg::SYM_W-1:0] sym;
	logic [afc37_pkg::SYM_W-1:0] diff;
	logic [afc37_pkg::SYM_W-1:0] op_a;
	logic [afc37_pkg::SYM_W-1:0] op_b;
	logic [10:0]                 prod;
	logic [10:0]                 sum;
	logic [6:0]                  folded;
	logic [afc37_pkg::SYM_W-1:0] res;
	logic                        is_dec;

	assign is_dec = (mode == afc37_pkg::MODE_DECRYPT);

	always_comb begin
		priority if (char_in >= afc37_pkg::ASCII_ZERO && char_in <= afc37_pkg::ASCII_NINE) begin
			sym = afc37_pkg::SYM_W'(char_in - afc37_pkg::ASCII_ZERO);
		end else if (char_in >= afc37_pkg::ASCII_LA && char_in <= afc37_pkg::ASCII_LZ) begin
			sym = afc37_pkg::SYM_W'(char_in - afc37_pkg::ASCII_LA)
				+ afc37_pkg::LETTER_BASE;
		end else if (char_in >= afc37_pkg::ASCII_UA && char_in <= afc37_pkg::ASCII_UZ) begin
			sym = afc37_pkg::SYM_W'(char_in - afc37_pkg::ASCII_UA)
				+ afc37_pkg::LETTER_BASE;
		end else begin
			sym = afc37_pkg::SPACE_SYM;
		end
	end

	// (sym - add) mod 37, both below 37
	assign diff = (sym >= keys.add) ? (sym - keys.add)
		: (sym + afc37_pkg::MODULUS - keys.add);

	// one shared multiplier: sym * mult on encrypt, diff * inv on decrypt
	// (both operands below 37, so the product fits in 11 bits)
	assign op_a = is_dec ? diff : sym;
	assign op_b = is_dec ? keys.inv : keys.mult;
	assign prod = {5'd0, op_a} * {5'd0, op_b};
	assign sum  = prod + (is_dec ? 11'd0 : {5'd0, keys.add});

	// fold the upper bits through a table, then one correction step
	assign folded = {1'b0, afc37_pkg::FOLD32_TABLE[sum[10:5]]} + {2'b00, sum[4:0]};

	always_comb begin
		if (is_dec && keys.mult == '0) begin
			res = afc37_pkg::SPACE_SYM;
		end else if (folded >= {1'b0, afc37_pkg::MODULUS}) begin
			res = afc37_pkg::SYM_W'(folded - {1'b0, afc37_pkg::MODULUS});
		end else begin
			res = folded[afc37_pkg::SYM_W-1:0];
		end
	end

	assign key_error = is_dec && (keys.mult == '0);

	always_comb begin
		priority if (res < afc37_pkg::SPACE_SYM) begin
			char_out = afc37_pkg::ASCII_ZERO + {2'b00, res};
		end else if (res == afc37_pkg::SPACE_SYM) begin
			char_out = afc37_pkg::ASCII_SPACE;
		end else begin
			char_out = afc37_pkg::ASCII_UA + {2'b00, res - afc37_pkg::LETTER_BASE};
		end
	end

endmodule

>>> rtl/core/affine_cipher_mod37_unit.sv
// Path: an accepted item is written to the input register, then to the result
// register, and is presented on the master side from the result register.
// Throughput: one item per cycle while m_tready holds; the single 6x6 multiply
// between the input register and the result register sets no further limit.
// Reset (arst_n low, asynchronous): both stages empty, key_mult 1, key_add 0.
// ----------------------------------------------------------------------------
// affine_cipher_mod37_unit: streaming affine cipher over a 37-symbol alphabet
// Encrypts or decrypts one ASCII character per item with two keyed registers.
// ----------------------------------------------------------------------------
module affine_cipher_mod37_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [afc37_pkg::IDX_W-1:0]  cfg_index,
	input  logic [afc37_pkg::SYM_W-1:0]  cfg_data,
	// slave side
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] char_in
	input  logic [0:0]                    s_tuser,   // [0] mode
	// master side
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] char_out
	output logic [0:0]                    m_tuser    // [0] key_error
);

	afc37_pkg::key_set_t          keys_q;
	logic [afc37_pkg::SYM_W-1:0]  wr_val;

	logic                         valid_s1;
	logic                         mode_s1;
	logic [afc37_pkg::CHAR_W-1:0] char_s1;

	logic                         valid_s2;
	logic [afc37_pkg::CHAR_W-1:0] char_s2;
	logic                         err_s2;

	logic                         adv_s2;
	logic                         adv_s1;
	logic [afc37_pkg::CHAR_W-1:0] char_x;
	logic                         err_x;

	// Configuration: always ready. Reduce the key once at write time and keep
	// the inverse beside it, so the per-item path sees clean symbols.
	assign cfg_ready = 1'b1;
	assign wr_val    = afc37_pkg::reduce37(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q.mult <= afc37_pkg::SYM_W'(1);
			keys_q.inv  <= afc37_pkg::SYM_W'(1);
			keys_q.add  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				afc37_pkg::REG_KEY_MULT: begin
					keys_q.mult <= wr_val;
					keys_q.inv  <= afc37_pkg::INV_TABLE[wr_val];
				end
				afc37_pkg::REG_KEY_ADD: begin
					keys_q.add <= wr_val;
				end
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	// Flow control: the result stage frees when empty or taken; the input
	// stage frees when empty or moving on. A full pipe keeps one item per cycle while m_tready holds.
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			mode_s1 <= s_tuser[0];
			char_s1 <= s_tdata;
		end
	end

	afc37_xform u_xform (
		.mode      (mode_s1),
		.char_in   (char_s1),
		.keys      (keys_q),
		.char_out  (char_x),
		.key_error (err_x)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			char_s2 <= char_x;
			err_s2  <= err_x;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = char_s2;
	assign m_tuser  = err_s2;

`ifndef SYNTHESIS
	// an error result always carries a space
	a_err_space: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == afc37_pkg::ASCII_SPACE)
		else $error("key_error result without space character");

	// stored keys stay reduced
	a_keys_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		keys_q.mult < afc37_pkg::MODULUS && keys_q.add < afc37_pkg::MODULUS)
		else $error("key register holds a value above 36");

	// the inverse is zero exactly when the multiplier is zero
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(keys_q.mult == '0) == (keys_q.inv == '0))
		else $error("inverse key out of step with multiplier");

	// an accepted item occupies the input stage next cycle
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted item lost before input stage");

	// a stalled input stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(char_s1) && $stable(mode_s1))
		else $error("input stage changed while stalled");
`endif

endmodule
